[rtl/assert_macros.svh]
// Assertion macros for the RTL files; only the top-level module includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lcdfb_pkg.sv]
// Types and constants for the mono LCD tiled framebuffer.
`timescale 1ns / 1ps
`default_nettype none
package lcdfb_pkg;

  localparam int MAP_ADDR_W = 17;
  localparam int DIV3_MUL   = 43;
  localparam int DIV3_SHIFT = 7;

  typedef enum logic [1:0] {
    REQ_PLOT  = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  col_pos;
    logic [7:0]  row_pos;
    logic        pixel_on;
    logic [11:0] byte_index;
  } lcdfb_in_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       range_error;
  } lcdfb_out_t;

  typedef struct packed {
    logic [MAP_ADDR_W-1:0] addr;
    logic [2:0]            bit_sel;
    logic                  err;
  } lcdfb_map_t;

endpackage
`default_nettype wire

[rtl/lcdfb_map.sv]
// Pixel coordinate to store byte and bit mapping.
`timescale 1ns / 1ps
`default_nettype none
module lcdfb_map
  import lcdfb_pkg::*;
#(
  parameter int PANEL_COLUMNS = 248,
  parameter int PANEL_ROWS    = 132,
  parameter int STORE_BYTES   = 4092
) (
  input  wire logic [7:0] col_pos,
  input  wire logic [7:0] row_pos,
  output lcdfb_map_t      map
);

  localparam int BAND_BYTES = ((PANEL_COLUMNS + 1) / 2) * 3;

  logic [5:0]            quad;
  logic [11:0]           quad_prod;
  logic [4:0]            band;
  logic [5:0]            band_x3;
  logic [5:0]            sub_full;
  logic [1:0]            sub;
  logic [7:0]            col_m1;
  logic [6:0]            pair;
  logic [MAP_ADDR_W-1:0] addr;
  logic [2:0]            bit_base;

  always_comb begin
    quad      = row_pos[7:2];
    quad_prod = 12'(quad) * 12'(DIV3_MUL);
    band      = 5'(quad_prod >> DIV3_SHIFT);
    band_x3   = 6'(band) * 6'd3;
    sub_full  = quad - band_x3;
    sub       = sub_full[1:0];
    col_m1    = col_pos - 8'd1;
    pair      = col_m1[7:1];
    addr      = MAP_ADDR_W'(pair) * MAP_ADDR_W'(3) + MAP_ADDR_W'(sub)
              + MAP_ADDR_W'(band) * MAP_ADDR_W'(BAND_BYTES);
    bit_base  = col_pos[0] ? 3'd7 : 3'd6;
    map.addr    = addr;
    map.bit_sel = bit_base - {row_pos[1:0], 1'b0};
    map.err     = (col_pos == 8'd0)
               || (11'(col_pos) > 11'(PANEL_COLUMNS))
               || (10'(row_pos) >= 10'(PANEL_ROWS))
               || (addr >= MAP_ADDR_W'(STORE_BYTES));
  end

endmodule
`default_nettype wire

[rtl/mono_lcd_tiled_framebuffer_plot.sv]
// Top level of the mono LCD tiled framebuffer with pixel plot, clear and byte read.
// For an in-range plot or read request the frame store is read on the accept edge;
// then, in ST_EXEC once the result register is free, a plot writes the modified byte
// back and the result is registered. A clear request zeroes one store byte per cycle
// through the single write port before its result. After reset the same sweep
// zeroes every store byte with in_stall held high. Results sit in an output
// register; one request is in flight at a time.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mono_lcd_tiled_framebuffer_plot
  import lcdfb_pkg::*;
#(
  parameter int PANEL_COLUMNS = 248,
  parameter int PANEL_ROWS    = 132,
  parameter int STORE_BYTES   = 4092
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire lcdfb_in_t  in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output lcdfb_out_t      out_data
);

  localparam int ADDR_W = $clog2(STORE_BYTES);

  logic [7:0] mem [STORE_BYTES];

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_r, clr_nxt;
  logic [1:0]          op_r, op_nxt;
  logic                err_r, err_nxt;
  logic                on_r, on_nxt;
  logic [2:0]          bit_r, bit_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic                out_valid_r, out_valid_nxt;
  lcdfb_out_t          out_data_r, out_data_nxt;
  logic [7:0]          rdata_r;

  lcdfb_map_t          map;
  logic                in_xfer;
  logic                out_free;
  logic                idx_err;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic                we;
  logic [ADDR_W-1:0]   wr_addr;
  logic [7:0]          wr_data;
  logic [7:0]          mask;
  logic                clr_last;

  lcdfb_map #(
    .PANEL_COLUMNS (PANEL_COLUMNS),
    .PANEL_ROWS    (PANEL_ROWS),
    .STORE_BYTES   (STORE_BYTES)
  ) u_map (
    .col_pos (in_data.col_pos),
    .row_pos (in_data.row_pos),
    .map     (map)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign idx_err   = (MAP_ADDR_W'(in_data.byte_index) >= MAP_ADDR_W'(STORE_BYTES));
  assign clr_last  = (clr_r == ADDR_W'(STORE_BYTES - 1));
  assign mask      = 8'd1 << bit_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    op_nxt        = op_r;
    err_nxt       = err_r;
    on_nxt        = on_r;
    bit_nxt       = bit_r;
    addr_nxt      = addr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    rd_addr       = ADDR_W'(map.addr);
    we            = 1'b0;
    wr_addr       = addr_r;
    wr_data       = on_r ? (rdata_r | mask) : (rdata_r & ~mask);
    case (state_r)
      ST_INIT: begin
        we      = 1'b1;
        wr_addr = clr_r;
        wr_data = 8'd0;
        clr_nxt = clr_r + ADDR_W'(1);
        if (clr_last) begin
          clr_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          op_nxt   = in_data.req_type;
          on_nxt   = in_data.pixel_on;
          bit_nxt  = map.bit_sel;
          addr_nxt = ADDR_W'(map.addr);
          err_nxt  = 1'b0;
          clr_nxt  = '0;
          state_nxt = ST_EXEC;
          case (in_data.req_type)
            REQ_PLOT: begin
              err_nxt = map.err;
              rd_en   = !map.err;
            end
            REQ_CLEAR: begin
              state_nxt = ST_CLEAR;
            end
            REQ_READ: begin
              err_nxt = idx_err;
              rd_en   = !idx_err;
              rd_addr = ADDR_W'(in_data.byte_index);
            end
            default: begin
            end
          endcase
        end
      end
      ST_CLEAR: begin
        we      = 1'b1;
        wr_addr = clr_r;
        wr_data = 8'd0;
        clr_nxt = clr_r + ADDR_W'(1);
        if (clr_last) begin
          clr_nxt   = '0;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          we = (op_r == REQ_PLOT) && !err_r;
          out_valid_nxt            = 1'b1;
          out_data_nxt.range_error = err_r;
          out_data_nxt.read_byte   = ((op_r == REQ_READ) && !err_r) ? rdata_r : 8'd0;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    err_r      <= err_nxt;
    on_r       <= on_nxt;
    bit_r      <= bit_nxt;
    addr_r     <= addr_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  `ASSERT_IMPL(a_no_result_in_init, clk, rst_n, state_r == ST_INIT, !out_valid_r,
               "result during init sweep")
  `ASSERT_NEXT(a_accept_moves_on, clk, rst_n, in_xfer,
               state_r == ST_EXEC || state_r == ST_CLEAR, "accept did not start work")
  `ASSERT_IMPL(a_exec_write_plot, clk, rst_n, we && state_r == ST_EXEC,
               op_r == REQ_PLOT && !err_r, "bad store write")
  `ASSERT_IMPL(a_result_from_exec, clk, rst_n, $rose(out_valid_r),
               $past(state_r == ST_EXEC), "result not from exec")

endmodule
`default_nettype wire
